// ===== sv/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and codes for the text console writer
// Request and response beats, controller commands and datapath status.
// ----------------------------------------------------------------------------
package tcw_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [7:0]  color;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_location;
    logic        scrolled;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } rsp_t;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_PRINT_MAX = 8'h7f;
  localparam logic [7:0] ATTR_BS      = 8'h0f;
  localparam logic [7:0] ATTR_SCROLL  = 8'h07;
  localparam int         TAB_STEP     = 8;

  localparam logic [1:0] PTR_HOLD     = 2'd0;
  localparam logic [1:0] PTR_ZERO     = 2'd1;
  localparam logic [1:0] PTR_LAST_ROW = 2'd2;
  localparam logic [1:0] PTR_INC      = 2'd3;

  localparam logic [2:0] MEM_NONE   = 3'd0;
  localparam logic [2:0] MEM_PUT    = 3'd1;
  localparam logic [2:0] MEM_SC_RD  = 3'd2;
  localparam logic [2:0] MEM_SC_WR  = 3'd3;
  localparam logic [2:0] MEM_FILL   = 3'd4;
  localparam logic [2:0] MEM_CLEAR  = 3'd5;
  localparam logic [2:0] MEM_ZERO   = 3'd6;
  localparam logic [2:0] MEM_RDCELL = 3'd7;

  typedef struct packed {
    logic       ld_in;
    logic       exec;
    logic       load_out;
    logic [1:0] ptr_op;
    logic [2:0] mem_op;
  } cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       need_scroll;
    logic       ptr_end;
    logic       copy_end;
    logic [1:0] opcode;
  } sts_t;

endpackage

// ===== sv/tcw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencer for the text console writer
// Accepts request beats and steps the datapath through put, scroll, clear,
// read and the zeroing pass after reset.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SC_RD = 3'd3;
  localparam logic [2:0] S_SC_WR = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_CLR   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_stall  = (state != S_IDLE);
    unique case (state)
      S_INIT: begin
        cmd.mem_op = MEM_ZERO;
        cmd.ptr_op = PTR_INC;
        if (sts.ptr_end) begin
          cmd.ptr_op = PTR_ZERO;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.ld_in  = 1'b1;
          cmd.ptr_op = PTR_ZERO;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        unique case (sts.opcode)
          OP_PUT: begin
            cmd.mem_op = MEM_PUT;
            state_next = sts.need_scroll ? S_SC_RD : S_DONE;
          end
          OP_CLEAR: begin
            state_next = S_CLR;
          end
          OP_READ: begin
            cmd.mem_op = MEM_RDCELL;
            state_next = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SC_RD: begin
        cmd.mem_op = MEM_SC_RD;
        state_next = S_SC_WR;
      end
      S_SC_WR: begin
        cmd.mem_op = MEM_SC_WR;
        if (sts.copy_end) begin
          cmd.ptr_op = PTR_LAST_ROW;
          state_next = S_FILL;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_next = S_SC_RD;
        end
      end
      S_FILL: begin
        cmd.mem_op = MEM_FILL;
        cmd.ptr_op = PTR_INC;
        if (sts.ptr_end) begin
          state_next = S_DONE;
        end
      end
      S_CLR: begin
        cmd.mem_op = MEM_CLEAR;
        cmd.ptr_op = PTR_INC;
        if (sts.ptr_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_EXEC))
    else $error("accepted beat did not start execution");

  a_scroll_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && sts.opcode == OP_PUT && sts.need_scroll) |=> (state == S_SC_RD))
    else $error("row overflow did not start a scroll");

  a_fill_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && sts.ptr_end) |=> (state == S_DONE))
    else $error("last row fill did not finish");

endmodule

// ===== sv/tcw_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_dpath: cursor, cell store and response register
// Holds the cursor, the character/attribute store, the sweep pointer and
// the response register; acts on controller commands.
// ----------------------------------------------------------------------------
module tcw_dpath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  tcw_pkg::cmd_t cmd,
  input  tcw_pkg::req_t req,
  input  logic          rsp_stall,
  output tcw_pkg::sts_t sts,
  output logic          rsp_valid,
  output tcw_pkg::rsp_t rsp
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int IDX_W  = (ADDR_W > 11) ? ADDR_W : 11;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  req_t              in_q;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              scrolled;
  logic              rd_hit;
  logic [ADDR_W-1:0] ptr;
  logic [15:0]       rdata;
  logic [15:0]       mem [CELLS];

  logic [COL_W:0]    col_w;
  logic [COL_W:0]    col_tab;
  logic [ROW_W:0]    row_w;
  logic              put_wr;
  logic [COL_W-1:0]  put_col;
  logic [15:0]       put_cell;
  logic              need_scroll;
  logic [IDX_W-1:0]  idx_ext;
  logic              idx_ok;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [15:0]       mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      in_q <= req;
    end
  end

  always_comb begin
    col_w    = (COL_W+1)'(col);
    row_w    = (ROW_W+1)'(row);
    col_tab  = (COL_W+1)'(col) + (COL_W+1)'(TAB_STEP);
    put_wr   = 1'b0;
    put_col  = col;
    put_cell = {ATTR_BS, CH_SPACE};
    if (in_q.opcode == OP_PUT) begin
      priority if (in_q.char_code == CH_BS && col != '0) begin
        col_w   = col_w - 1'b1;
        put_col = col - 1'b1;
        put_wr  = 1'b1;
      end else if (in_q.char_code == CH_TAB) begin
        col_w = {col_tab[COL_W:3], 3'b000};
      end else if (in_q.char_code == CH_CR) begin
        col_w = '0;
      end else if (in_q.char_code == CH_LF) begin
        col_w = '0;
        row_w = row_w + 1'b1;
      end else if (in_q.char_code >= CH_SPACE && in_q.char_code <= CH_PRINT_MAX) begin
        put_wr   = 1'b1;
        put_cell = {in_q.color, in_q.char_code};
        col_w    = col_w + 1'b1;
      end else begin
        put_wr = 1'b0;
      end
      if (col_w >= (COL_W+1)'(COLUMNS)) begin
        col_w = '0;
        row_w = row_w + 1'b1;
      end
    end
    need_scroll = (row_w >= (ROW_W+1)'(ROWS));
  end

  assign idx_ext = IDX_W'(in_q.cell_index);
  assign idx_ok  = (idx_ext < IDX_W'(CELLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      scrolled <= 1'b0;
      rd_hit   <= 1'b0;
    end else begin
      if (cmd.ld_in) begin
        rd_hit <= 1'b0;
      end else if (cmd.mem_op == MEM_RDCELL) begin
        rd_hit <= idx_ok;
      end
      if (cmd.exec) begin
        scrolled <= (in_q.opcode == OP_PUT) && need_scroll;
        if (in_q.opcode == OP_PUT) begin
          col <= col_w[COL_W-1:0];
          row <= need_scroll ? ROW_W'(ROWS - 1) : row_w[ROW_W-1:0];
        end else if (in_q.opcode == OP_CLEAR) begin
          col <= '0;
          row <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      unique case (cmd.ptr_op)
        PTR_HOLD:     ptr <= ptr;
        PTR_ZERO:     ptr <= '0;
        PTR_LAST_ROW: ptr <= ADDR_W'(CELLS - COLUMNS);
        PTR_INC:      ptr <= ptr + 1'b1;
      endcase
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = ptr;
    unique case (cmd.mem_op)
      MEM_NONE: begin
        mem_we = 1'b0;
      end
      MEM_PUT: begin
        mem_we = put_wr;
        mem_wa = cell_addr(row, put_col);
        mem_wd = put_cell;
      end
      MEM_SC_RD: begin
        mem_re = 1'b1;
        mem_ra = ptr + ADDR_W'(COLUMNS);
      end
      MEM_SC_WR: begin
        mem_we = 1'b1;
        mem_wd = rdata;
      end
      MEM_FILL: begin
        mem_we = 1'b1;
        mem_wd = {ATTR_SCROLL, CH_SPACE};
      end
      MEM_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = {in_q.color, CH_SPACE};
      end
      MEM_ZERO: begin
        mem_we = 1'b1;
        mem_wd = '0;
      end
      MEM_RDCELL: begin
        mem_re = idx_ok;
        mem_ra = idx_ext[ADDR_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.cursor_col      <= 7'(col);
      rsp.cursor_row      <= 5'(row);
      rsp.cursor_location <= 11'(cell_addr(row, col));
      rsp.scrolled        <= scrolled;
      rsp.read_char       <= rd_hit ? rdata[7:0] : 8'h00;
      rsp.read_attr       <= rd_hit ? rdata[15:8] : 8'h00;
    end
  end

  assign sts.out_free    = !rsp_valid || !rsp_stall;
  assign sts.need_scroll = need_scroll;
  assign sts.ptr_end     = (ptr == ADDR_W'(CELLS - 1));
  assign sts.copy_end    = (ptr == ADDR_W'(CELLS - COLUMNS - 1));
  assign sts.opcode      = in_q.opcode;

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (COL_W+1)'(col) < (COL_W+1)'(COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (ROW_W+1)'(row) < (ROW_W+1)'(ROWS))
    else $error("cursor row out of range");

  a_scroll_put_only: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && in_q.opcode != OP_PUT) |=> !rsp.scrolled)
    else $error("scroll flagged for a non-put beat");

endmodule

// ===== sv/text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console over a COLUMNS x ROWS cell store
// Request beats (req) carry put, clear or read; each gives one response
// beat (rsp) with the cursor after the beat, a scroll flag and read data.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. One request is worked on at a time; req_stall is high otherwise.
// A put that scrolls moves each row up by one, with one store read and one
// store write per cell, then blanks the last row. A clear makes one store
// write per cell. The sequencer makes at most one store access per cycle.
// After reset the store is zeroed one cell a cycle, with req_stall high.
// While rsp is stalled the response holds; the next request is still
// accepted and worked on, and its response waits until the register frees.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tcw_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tcw_pkg::rsp_t rsp
);
  import tcw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule
